// ===== rtl/cot_pkg.sv =====
// Shared types and constants for the circle occupancy table.
// Used by circle_occupancy_table; no dependencies of its own.
package cot_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int ADDR_W      = $clog2(MAX_REGIONS);
  localparam int CNT_W       = 7;
  localparam int COORD_W     = 16;
  localparam int RAD_W       = 15;

  // Input function codes.
  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ORIGIN_X       = 2'd0,
    REG_ORIGIN_Y       = 2'd1,
    REG_SURFACE_WIDTH  = 2'd2,
    REG_SURFACE_HEIGHT = 2'd3
  } cfg_reg_t;

  // One stored circle.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RAD_W-1:0]   r;
  } circle_t;

  localparam int CIRCLE_W = $bits(circle_t);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

// ===== rtl/cot_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/circle_occupancy_table.sv =====
// Top level of the circle occupancy table: sequencer, pipelined overlap unit
// and result register. Depends on cot_pkg and cot_ram.
//
// Usage. One input beat (in_func, centre, radius) yields one result beat.
// A mark beat (func 0) appends the circle to the table; when the table holds
// its capacity the circle is dropped and out_table_full is set. A query beat
// (func 1) first checks that the circle lies inside the configured rectangle
// and, if so, runs every stored circle through one shared overlap unit, one
// entry per cycle: |dx|, |dy| and the radius sum, then their squares, then
// a sum and compare. A query is free when it is inside and hits nothing.
// A mark, and a query that is outside the surface or meets an empty table, go
// from the check step straight to the finish step; any other query first
// walks the stored entries in the scan step until the overlap pipeline has
// drained. The block works on one beat at a time and stalls its input until
// the result has been loaded into the output register. A finished result
// waits in that register while out_stall is high; the next beat is accepted
// meanwhile and is held in the finish step until the register frees.
// Synchronous reset empties the table and clears the surface registers;
// store contents are left as they are, since only entries below the count
// are ever read.
module circle_occupancy_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [cot_pkg::COORD_W-1:0]   cfg_wdata,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic signed [cot_pkg::COORD_W-1:0] in_centre_x,
  input  logic signed [cot_pkg::COORD_W-1:0] in_centre_y,
  input  logic [cot_pkg::RAD_W-1:0]     in_circle_radius,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_free,
  output logic                          out_inside_surface,
  output logic                          out_table_full,
  output logic [cot_pkg::CNT_W-1:0]     out_entries_stored
);

  localparam int CW = cot_pkg::COORD_W;
  localparam int AW = cot_pkg::ADDR_W;
  localparam int NW = cot_pkg::CNT_W;
  // Bounds need two extra bits: coordinate plus radius or width.
  localparam int BW = CW + 2;

  // Surface registers.
  logic signed [CW-1:0] origin_x_r, origin_y_r;
  logic        [CW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= '0;
      height_r   <= '0;
    end else if (cfg_we) begin
      case (cot_pkg::cfg_reg_t'(cfg_index))
        cot_pkg::REG_ORIGIN_X:       origin_x_r <= cfg_wdata;
        cot_pkg::REG_ORIGIN_Y:       origin_y_r <= cfg_wdata;
        cot_pkg::REG_SURFACE_WIDTH:  width_r    <= cfg_wdata;
        cot_pkg::REG_SURFACE_HEIGHT: height_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and item registers.
  cot_pkg::state_t state_r, state_nxt;
  cot_pkg::circle_t item_r;
  logic func_r;
  logic [NW-1:0] count_r;
  logic [NW-1:0] idx_r;
  logic inside_r, full_r, hit_r;

  logic in_accept;
  assign in_stall  = (state_r != cot_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Surface containment check on the held item.
  logic signed [BW-1:0] x_lo, x_hi, y_lo, y_hi, x_min, x_max, y_min, y_max;
  logic in_rect;

  always_comb begin
    x_lo  = BW'(item_r.x) - BW'(signed'({1'b0, item_r.r}));
    x_hi  = BW'(item_r.x) + BW'(signed'({1'b0, item_r.r}));
    y_lo  = BW'(item_r.y) - BW'(signed'({1'b0, item_r.r}));
    y_hi  = BW'(item_r.y) + BW'(signed'({1'b0, item_r.r}));
    x_min = BW'(origin_x_r);
    y_min = BW'(origin_y_r);
    x_max = BW'(origin_x_r) + BW'(signed'({1'b0, width_r}));
    y_max = BW'(origin_y_r) + BW'(signed'({1'b0, height_r}));
    in_rect = (x_lo >= x_min) && (x_hi <= x_max) && (y_lo >= y_min) && (y_hi <= y_max);
  end

  logic table_is_full;
  assign table_is_full = (count_r >= NW'(cot_pkg::MAX_REGIONS));

  // Circle store.
  logic            ram_we;
  cot_pkg::circle_t ram_rdata;

  assign ram_we = (state_r == cot_pkg::ST_CHECK) && (func_r == cot_pkg::FUNC_MARK) &&
                  !table_is_full;

  cot_ram #(
    .WIDTH (cot_pkg::CIRCLE_W),
    .DEPTH (cot_pkg::MAX_REGIONS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (item_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Overlap pipeline: read, differences, squares, compare.
  logic issue;
  logic v1_r, v2_r, v3_r;
  logic [CW-1:0] adx_r, ady_r, rs_r;
  logic [2*CW-1:0] sqx_r, sqy_r, sqr_r;
  logic signed [CW:0] dx, dy;
  logic [CW:0] adx, ady;
  logic [2*CW:0] d2;
  logic hit_now;

  assign issue = (state_r == cot_pkg::ST_SCAN) && (idx_r < count_r);

  always_comb begin
    dx  = (CW+1)'(item_r.x) - (CW+1)'(ram_rdata.x);
    dy  = (CW+1)'(item_r.y) - (CW+1)'(ram_rdata.y);
    adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    d2  = (2*CW+1)'(sqx_r) + (2*CW+1)'(sqy_r);
    hit_now = v3_r && (d2 < (2*CW+1)'(sqr_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    adx_r <= adx[CW-1:0];
    ady_r <= ady[CW-1:0];
    rs_r  <= CW'(item_r.r) + CW'(ram_rdata.r);
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    sqr_r <= rs_r * rs_r;
  end

  // Result register.
  logic out_valid_r, out_free_r, out_inside_r, out_full_r;
  logic [NW-1:0] out_count_r;
  logic load_out;

  assign load_out = (state_r == cot_pkg::ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cot_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = cot_pkg::ST_CHECK;
      end
      cot_pkg::ST_CHECK: begin
        if (func_r == cot_pkg::FUNC_QUERY && in_rect && count_r != '0) begin
          state_nxt = cot_pkg::ST_SCAN;
        end else begin
          state_nxt = cot_pkg::ST_FINISH;
        end
      end
      cot_pkg::ST_SCAN: begin
        if (!issue && !v1_r && !v2_r && !v3_r) state_nxt = cot_pkg::ST_FINISH;
      end
      cot_pkg::ST_FINISH: begin
        if (load_out) state_nxt = cot_pkg::ST_IDLE;
      end
      default: state_nxt = cot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cot_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) count_r <= count_r + NW'(1);
      if (state_r == cot_pkg::ST_CHECK) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + NW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r   <= in_func;
      item_r.x <= in_centre_x;
      item_r.y <= in_centre_y;
      item_r.r <= in_circle_radius;
    end
    if (state_r == cot_pkg::ST_CHECK) begin
      inside_r <= in_rect;
      full_r   <= (func_r == cot_pkg::FUNC_MARK) && table_is_full;
      hit_r    <= 1'b0;
    end else if (hit_now) begin
      hit_r <= 1'b1;
    end
    if (load_out) begin
      out_free_r   <= (func_r == cot_pkg::FUNC_QUERY) && inside_r && !hit_r;
      out_inside_r <= inside_r;
      out_full_r   <= full_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_free        = out_free_r;
  assign out_inside_surface = out_inside_r;
  assign out_table_full     = out_full_r;
  assign out_entries_stored = out_count_r;

endmodule

// ===== bench/cot_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the circle occupancy table: keeps its own copy of the table and
// the surface registers, predicts every result beat and compares it field by field.
// Depends on cot_pkg for widths, codes and the stored circle type.
module cot_checker
  import cot_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_func,
  input  logic signed [COORD_W-1:0] in_centre_x,
  input  logic signed [COORD_W-1:0] in_centre_y,
  input  logic [RAD_W-1:0]          in_circle_radius,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_is_free,
  input  logic                      out_inside_surface,
  input  logic                      out_table_full,
  input  logic [CNT_W-1:0]          out_entries_stored,
  output int                        mismatches,
  output int                        pending,
  output int                        free_count,
  output int                        blocked_count,
  output int                        outside_count,
  output int                        dropped_count
);

  typedef struct packed {
    logic             is_query;
    logic             is_free;
    logic             in_rect;
    logic             full;
    logic [CNT_W-1:0] count;
  } occupancy_t;

  occupancy_t                expected_results[$];
  occupancy_t                want;
  circle_t                   occupied[MAX_REGIONS];
  int unsigned               occupied_count;
  logic signed [COORD_W-1:0] left_x;
  logic signed [COORD_W-1:0] bottom_y;
  logic [COORD_W-1:0]        span_w;
  logic [COORD_W-1:0]        span_h;

  function automatic logic lies_inside(longint x, longint y, longint r);
    return (x - r >= longint'(left_x)) &&
           (x + r <= longint'(left_x) + longint'(span_w)) &&
           (y - r >= longint'(bottom_y)) &&
           (y + r <= longint'(bottom_y) + longint'(span_h));
  endfunction

  // Overlap is a strict compare of squared distance against squared radius sum.
  function automatic logic hits(longint x, longint y, longint r, circle_t c);
    longint dx;
    longint dy;
    longint rs;
    dx = x - longint'($signed(c.x));
    dy = y - longint'($signed(c.y));
    rs = r + longint'(c.r);
    return dx * dx + dy * dy < rs * rs;
  endfunction

  function automatic occupancy_t predict_occupancy(logic func, logic signed [COORD_W-1:0] cx,
                                                   logic signed [COORD_W-1:0] cy,
                                                   logic [RAD_W-1:0] cr);
    occupancy_t res;
    longint     x;
    longint     y;
    longint     r;
    int         i;
    x = longint'(cx);
    y = longint'(cy);
    r = longint'(cr);
    res = '0;
    res.is_query = (func == FUNC_QUERY);
    res.in_rect = lies_inside(x, y, r);
    if (func == FUNC_MARK) begin
      if (occupied_count >= MAX_REGIONS) begin
        res.full = 1'b1;
      end else begin
        occupied[occupied_count].x = cx;
        occupied[occupied_count].y = cy;
        occupied[occupied_count].r = cr;
        occupied_count++;
      end
    end else if (res.in_rect) begin
      res.is_free = 1'b1;
      for (i = 0; i < occupied_count; i++) begin
        if (hits(x, y, r, occupied[i])) res.is_free = 1'b0;
      end
    end
    res.count = occupied_count[CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(string field, logic [7:0] expected_value, logic [7:0] actual_value);
    if (actual_value !== expected_value) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, expected_value, actual_value);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      occupied_count = 0;
      left_x = '0;
      bottom_y = '0;
      span_w = '0;
      span_h = '0;
      mismatches = 0;
      free_count = 0;
      blocked_count = 0;
      outside_count = 0;
      dropped_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:       left_x = cfg_wdata;
          REG_ORIGIN_Y:       bottom_y = cfg_wdata;
          REG_SURFACE_WIDTH:  span_w = cfg_wdata;
          REG_SURFACE_HEIGHT: span_h = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, actual free=%0b inside=%0b",
                   $time, out_is_free, out_inside_surface);
        end else begin
          want = expected_results.pop_front();
          check_field("is_free", 8'(want.is_free), 8'(out_is_free));
          check_field("inside_surface", 8'(want.in_rect), 8'(out_inside_surface));
          check_field("table_full", 8'(want.full), 8'(out_table_full));
          check_field("entries_stored", 8'(want.count), 8'(out_entries_stored));
          if (want.full) dropped_count++;
          else if (want.is_free) free_count++;
          if (want.is_query && !want.is_free && want.in_rect) blocked_count++;
          if (!want.in_rect) outside_count++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                predict_occupancy(in_func, in_centre_x, in_centre_y,
                                                  in_circle_radius));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the circle occupancy table bench: clock, reset, surface programming and
// beat stimulus. Depends on cot_pkg, circle_occupancy_table and cot_checker.
module tb;
  import cot_pkg::*;

  // The longest quiet stretch of a correct run is the deliberate long receiver
  // hold plus one full-table query, well under this figure.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  // Settle time covers a query against a full table.
  localparam int SETTLE_CYCLES  = MAX_REGIONS + 16;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [COORD_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_func = FUNC_MARK;
  logic signed [COORD_W-1:0] in_centre_x = '0;
  logic signed [COORD_W-1:0] in_centre_y = '0;
  logic [RAD_W-1:0]          in_circle_radius = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_is_free;
  logic                      out_inside_surface;
  logic                      out_table_full;
  logic [CNT_W-1:0]          out_entries_stored;

  int mismatches;
  int pending_results;
  int free_count;
  int blocked_count;
  int outside_count;
  int dropped_count;

  // Stimulus bookkeeping. The cur_* copies of the surface only steer the
  // generator towards the rectangle edges; prediction lives in the checker.
  bit tx_idling = 1'b0;
  bit rx_idling = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int beats_sent = 0;
  int marks_sent = 0;
  int settings_used = 0;
  int cur_ox = 0;
  int cur_oy = 0;
  int cur_w = 0;
  int cur_h = 0;

  always #5 clk = ~clk;

  circle_occupancy_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_centre_x        (in_centre_x),
    .in_centre_y        (in_centre_y),
    .in_circle_radius   (in_circle_radius),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_free        (out_is_free),
    .out_inside_surface (out_inside_surface),
    .out_table_full     (out_table_full),
    .out_entries_stored (out_entries_stored)
  );

  cot_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_centre_x        (in_centre_x),
    .in_centre_y        (in_centre_y),
    .in_circle_radius   (in_circle_radius),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_free        (out_is_free),
    .out_inside_surface (out_inside_surface),
    .out_table_full     (out_table_full),
    .out_entries_stored (out_entries_stored),
    .mismatches         (mismatches),
    .pending            (pending_results),
    .free_count         (free_count),
    .blocked_count      (blocked_count),
    .outside_count      (outside_count),
    .dropped_count      (dropped_count)
  );

  // Result side. The stall is driven at the falling edge. A pending long-hold
  // request wins over starting a random burst but waits for a running one;
  // the hold is counted here so the sender is free to offer beats meanwhile.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_requests != holds_done) begin
      holds_done++;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (rx_idling && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted beat or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Offer one beat at the falling edge and return at the falling edge after
  // it was taken. Valid stays high on return, so a following beat goes out
  // back to back; a sender gap lowers it for a random burst first.
  task automatic send_item(logic func, int x, int y, int r);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_centre_x <= x[COORD_W-1:0];
    in_centre_y <= y[COORD_W-1:0];
    in_circle_radius <= r[RAD_W-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
    if (func == FUNC_MARK) marks_sent++;
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  // Writes all four surface registers; only called with the block idle.
  task automatic program_surface(int ox, int oy, int w, int h);
    cur_ox = int'($signed(ox[COORD_W-1:0]));
    cur_oy = int'($signed(oy[COORD_W-1:0]));
    cur_w = int'(w[COORD_W-1:0]);
    cur_h = int'(h[COORD_W-1:0]);
    settings_used++;
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_wdata <= ox[COORD_W-1:0];
    @(negedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_wdata <= oy[COORD_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_wdata <= w[COORD_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SURFACE_HEIGHT;
    cfg_wdata <= h[COORD_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Until the table is full, marks are mostly small circles in a central
  // cluster, so that later queries find both free and blocked spots. Once the
  // table is full every mark is dropped and the fields can run wild.
  task automatic random_mark();
    int x;
    int y;
    int r;
    if (marks_sent < MAX_REGIONS && $urandom_range(0, 9) != 0) begin
      x = $urandom_range(0, 6000) - 3000;
      y = $urandom_range(0, 6000) - 3000;
      r = $urandom_range(0, 400);
    end else begin
      x = $urandom;
      y = $urandom;
      r = (marks_sent < MAX_REGIONS) ? $urandom_range(0, 1023) : $urandom;
    end
    send_item(FUNC_MARK, x, y, r);
  endtask

  // Queries: cluster probes, probes that graze one edge of the rectangle by
  // at most one unit either way, and fully random fields.
  task automatic random_query();
    int x;
    int y;
    int r;
    int d;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      x = $urandom_range(0, 6000) - 3000;
      y = $urandom_range(0, 6000) - 3000;
      r = $urandom_range(0, 500);
    end else if (pick < 80) begin
      r = $urandom_range(0, 300);
      d = int'($urandom_range(0, 2)) - 1;
      x = cur_ox + int'($urandom_range(0, cur_w));
      y = cur_oy + int'($urandom_range(0, cur_h));
      case ($urandom_range(0, 3))
        0: x = cur_ox + r + d;
        1: x = cur_ox + cur_w - r + d;
        2: y = cur_oy + r + d;
        default: y = cur_oy + cur_h - r + d;
      endcase
    end else begin
      x = $urandom;
      y = $urandom;
      r = $urandom;
    end
    send_item(FUNC_QUERY, x, y, r);
  endtask

  // One random phase. Idling is re-rolled every hundred beats so that runs
  // with and without gaps are mixed; now and then the sender waits for the
  // block to empty completely.
  task automatic run_phase(int items, int mark_pct, bit allow_idle);
    int n;
    for (n = 0; n < items; n++) begin
      if (n % 100 == 0) begin
        tx_idling = allow_idle && $urandom_range(0, 3) != 0;
        rx_idling = allow_idle && $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < mark_pct) random_mark();
      else random_query();
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset surface is a single point at the origin: only a radius-zero
    // circle exactly there is inside. Two point circles never overlap.
    send_item(FUNC_QUERY, 0, 0, 0);
    send_item(FUNC_QUERY, 1, 0, 0);
    send_item(FUNC_QUERY, 0, 0, 1);
    send_item(FUNC_MARK, 0, 0, 0);
    send_item(FUNC_QUERY, 0, 0, 0);
    drain();

    // Widest possible surface; the largest radius fits only around the centre.
    program_surface(-32768, -32768, 65535, 65535);
    send_item(FUNC_QUERY, 0, 0, 32767);
    send_item(FUNC_QUERY, -1, -1, 32767);
    send_item(FUNC_QUERY, 1, 0, 32767);
    send_item(FUNC_QUERY, -32768, -32768, 0);
    send_item(FUNC_QUERY, 32767, 32767, 0);
    send_item(FUNC_MARK, 32767, -32768, 0);
    send_item(FUNC_MARK, -32768, 32767, 0);
    // Touching circles are not an overlap; one unit closer is.
    send_item(FUNC_MARK, 100, 0, 50);
    send_item(FUNC_QUERY, 200, 0, 50);
    send_item(FUNC_QUERY, 199, 0, 50);
    send_item(FUNC_QUERY, 100, 70, 0);
    // A mark outside the surface is still stored; a query outside it is
    // answered without walking the table.
    send_item(FUNC_MARK, 32767, 0, 1);
    send_item(FUNC_QUERY, 32767, 0, 2);
    drain();

    program_surface(-4096, -4096, 8192, 8192);
    run_phase(250, 40, 1'b1);
    while (marks_sent < MAX_REGIONS) random_mark();
    // Table full: marks with extreme fields are dropped.
    send_item(FUNC_MARK, -32768, 32767, 32767);
    send_item(FUNC_MARK, 32767, -32768, 0);
    drain();

    // Hold the result side for a long stretch while beats keep coming, so the
    // block fills up and stalls its input.
    tx_idling = 1'b0;
    hold_requests++;
    repeat (12) random_query();
    drain();

    program_surface(-32768, -32768, 65535, 65535);
    run_phase(250, 15, 1'b1);
    drain();
    program_surface(32767, 32767, 0, 0);
    run_phase(100, 15, 1'b1);
    drain();
    program_surface(-1000, 500, 3000, 1200);
    run_phase(200, 15, 1'b1);
    drain();
    program_surface($urandom, $urandom, $urandom, $urandom);
    run_phase(150, 15, 1'b1);
    drain();

    // Closing stretch without any idling on either side.
    program_surface(-3500, -3500, 7000, 7000);
    run_phase(200, 20, 1'b0);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d beats (%0d marks) under %0d surface settings.",
             beats_sent, marks_sent, settings_used);
    $display("Results: %0d free, %0d blocked, %0d outside the surface, %0d marks dropped.",
             free_count, blocked_count, outside_count, dropped_count);
    if (mismatches == 0 && pending_results == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cot_pkg.sv
rtl/cot_ram.sv
rtl/circle_occupancy_table.sv
bench/cot_checker.sv
bench/tb.sv
